// File: hdl/hte_pkg.sv
// Shared types, entity tables and helper functions for the HTML text escaper.
`timescale 1ns / 1ps

package hte_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int RUN_IDX_W   = 5;

    localparam logic [7:0] CHAR_LT  = 8'h3C;
    localparam logic [7:0] CHAR_GT  = 8'h3E;
    localparam logic [7:0] CHAR_CR  = 8'h0D;
    localparam logic [7:0] CHAR_LF  = 8'h0A;
    localparam logic [7:0] CHAR_SP  = 8'h20;
    localparam logic [7:0] CHAR_TAB = 8'h09;

    localparam logic [7:0] LT_RUN [4]   = '{8'h26, 8'h6C, 8'h74, 8'h3B};
    localparam logic [7:0] GT_RUN [4]   = '{8'h26, 8'h67, 8'h74, 8'h3B};
    localparam logic [7:0] BR_RUN [4]   = '{8'h3C, 8'h62, 8'h72, 8'h3E};
    localparam logic [7:0] NBSP_RUN [6] = '{8'h26, 8'h6E, 8'h62, 8'h73, 8'h70, 8'h3B};
    localparam logic [7:0] TAB_RUN [18] = '{
        8'h26, 8'h6E, 8'h62, 8'h73, 8'h70, 8'h3B,
        8'h26, 8'h6E, 8'h62, 8'h73, 8'h70, 8'h3B,
        8'h26, 8'h6E, 8'h62, 8'h73, 8'h70, 8'h3B
    };

    typedef enum logic [2:0] {
        CLS_PASS,
        CLS_LT,
        CLS_GT,
        CLS_BR,
        CLS_NBSP,
        CLS_TAB,
        CLS_DROP
    } cls_t;

    typedef struct packed {
        cls_t       cls;
        logic [7:0] raw;
    } item_t;

    // Index of the final byte of the run that a class produces.
    function automatic logic [RUN_IDX_W-1:0] run_last(input cls_t cls);
        logic [RUN_IDX_W-1:0] last;
        unique case (cls)
            CLS_LT, CLS_GT, CLS_BR: last = RUN_IDX_W'(3);
            CLS_NBSP:               last = RUN_IDX_W'(5);
            CLS_TAB:                last = RUN_IDX_W'(17);
            default:                last = '0;
        endcase
        return last;
    endfunction

    function automatic logic [7:0] run_byte(input cls_t cls, input logic [RUN_IDX_W-1:0] idx,
                                            input logic [7:0] raw);
        logic [7:0] b;
        unique case (cls)
            CLS_LT:   b = LT_RUN[idx[1:0]];
            CLS_GT:   b = GT_RUN[idx[1:0]];
            CLS_BR:   b = BR_RUN[idx[1:0]];
            CLS_NBSP: b = NBSP_RUN[idx[2:0]];
            CLS_TAB:  b = TAB_RUN[idx];
            default:  b = raw;
        endcase
        return b;
    endfunction

endpackage

// File: hdl/hte_front.sv
// Front end: sorts each accepted byte into the kind of run it expands to.
`timescale 1ns / 1ps

module hte_front (
    input  logic          esc_ws,
    input  logic [7:0]    in_byte,
    output hte_pkg::item_t item
);

    always_comb
    begin
        item.raw = in_byte;
        priority if (in_byte == hte_pkg::CHAR_LT)
            item.cls = hte_pkg::CLS_LT;
        else if (in_byte == hte_pkg::CHAR_GT)
            item.cls = hte_pkg::CLS_GT;
        else if (esc_ws && in_byte == hte_pkg::CHAR_CR)
            item.cls = hte_pkg::CLS_DROP;
        else if (esc_ws && in_byte == hte_pkg::CHAR_LF)
            item.cls = hte_pkg::CLS_BR;
        else if (esc_ws && in_byte == hte_pkg::CHAR_SP)
            item.cls = hte_pkg::CLS_NBSP;
        else if (esc_ws && in_byte == hte_pkg::CHAR_TAB)
            item.cls = hte_pkg::CLS_TAB;
        else
            item.cls = hte_pkg::CLS_PASS;
    end

endmodule

// File: hdl/hte_queue.sv
// Short queue of classified items between the front end and the run emitter.
`timescale 1ns / 1ps

module hte_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  hte_pkg::item_t wr_item,
    output logic           full,
    input  logic           rd_en,
    output logic           rd_valid,
    output hte_pkg::item_t rd_item
);

    hte_pkg::item_t                    mem [hte_pkg::QUEUE_DEPTH];
    logic [hte_pkg::QUEUE_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [hte_pkg::QUEUE_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [hte_pkg::QUEUE_CNT_W-1:0]   count_reg, count_next;

    assign full     = (count_reg == hte_pkg::QUEUE_CNT_W'(hte_pkg::QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_item  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_en ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = rd_en ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        unique case ({wr_en, rd_en})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_ptr_reg] <= wr_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: hdl/hte_back.sv
// Back end: walks the run of the head item into an output register, one byte per cycle when it is empty or popped.
`timescale 1ns / 1ps

module hte_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    input  hte_pkg::item_t q_item,
    output logic           q_pop,
    output logic           empty,
    input  logic           pop,
    output logic [7:0]     out_byte,
    output logic           last_of_run
);

    logic [hte_pkg::RUN_IDX_W-1:0] idx_reg, idx_next;
    logic                          valid_reg, valid_next;
    logic [7:0]                    byte_reg;
    logic                          last_reg;
    logic                          load;
    logic                          at_last;

    assign empty       = !valid_reg;
    assign out_byte    = byte_reg;
    assign last_of_run = last_reg;

    // With an item queued, the output register refills when it is empty or its byte is being taken.
    assign load    = q_valid && (!valid_reg || pop);
    assign at_last = (idx_reg == hte_pkg::run_last(q_item.cls));
    assign q_pop   = load && at_last;

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load)
        begin
            idx_next   = at_last ? '0 : idx_reg + 1'b1;
            valid_next = 1'b1;
        end
        else if (pop)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= hte_pkg::run_byte(q_item.cls, idx_reg, q_item.raw);
            last_reg <= at_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

endmodule

// File: hdl/html_text_escaper.sv
// Top level of the HTML text escaper.
`timescale 1ns / 1ps

// Each input byte expands into a run of escaped bytes, the last marked by last_of_run.
// Plain bytes emit themselves; CR, with whitespace escaping on, emits nothing. An entity run
// emits 4 bytes for angle brackets and newline, 6 for space and 18 for tab, one byte per
// cycle while the back end's output is free or popped. A four-entry queue between
// classification and emission accepts input while a run drains, until it is full.
// Write escape_whitespace on the configuration channel only while the block is idle.
module html_text_escaper (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] in_byte,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] out_byte,
    output logic       last_of_run,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data
);

    logic           esc_ws_reg;
    hte_pkg::item_t front_item;
    hte_pkg::item_t q_item;
    logic           q_full;
    logic           q_valid;
    logic           q_pop;
    logic           accept;
    logic           q_wr;

    assign cfg_ready = 1'b1;
    assign full      = q_full;
    assign accept    = push && !q_full;
    // Dropped bytes complete their transfer but never enter the queue.
    assign q_wr      = accept && (front_item.cls != hte_pkg::CLS_DROP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            esc_ws_reg <= 1'b1;
        else if (cfg_valid && cfg_ready)
            esc_ws_reg <= cfg_data;
    end

    hte_front u_front (
        .esc_ws  (esc_ws_reg),
        .in_byte (in_byte),
        .item    (front_item)
    );

    hte_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (q_wr),
        .wr_item  (front_item),
        .full     (q_full),
        .rd_en    (q_pop),
        .rd_valid (q_valid),
        .rd_item  (q_item)
    );

    hte_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop),
        .empty       (empty),
        .pop         (pop),
        .out_byte    (out_byte),
        .last_of_run (last_of_run)
    );

endmodule

// File: tb/html_text_escaper_test.sv
// Self-checking testbench for the HTML text escaper: directed table, then randomized phases.
`timescale 1ns / 1ps

module html_text_escaper_test;

    localparam int NUM_ROWS     = 22;
    localparam int PHASE_ITEMS  = 77;
    localparam int DRAIN_CYCLES = 32;
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct packed {
        logic [7:0] ch;
        logic       tail;
    } out_beat_t;

    typedef struct packed {
        logic       esc;
        logic [7:0] ch;
        logic       typed;
        logic [7:0] want;
    } stim_row_t;

    logic       clk;
    logic       rst_n;
    logic       push;
    logic       full;
    logic [7:0] in_byte;
    logic       empty;
    logic       pop;
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       cfg_valid;
    logic       cfg_ready;
    logic       cfg_data;

    out_beat_t  escaped_q[$];
    logic       esc_on;
    int         rx_stall_pct;
    int         fail_count;
    int         cycle_count;

    // Plain bytes are typed in directly; entity runs come from the predictor.
    stim_row_t stim_table [NUM_ROWS] = '{
        '{1'b1, 8'h00,             1'b1, 8'h00},
        '{1'b1, 8'hFF,             1'b1, 8'hFF},
        '{1'b1, hte_pkg::CHAR_LT,  1'b0, 8'h00},
        '{1'b1, hte_pkg::CHAR_GT,  1'b0, 8'h00},
        '{1'b1, hte_pkg::CHAR_CR,  1'b0, 8'h00},
        '{1'b1, hte_pkg::CHAR_LF,  1'b0, 8'h00},
        '{1'b1, hte_pkg::CHAR_SP,  1'b0, 8'h00},
        '{1'b1, hte_pkg::CHAR_TAB, 1'b0, 8'h00},
        '{1'b1, 8'h41,             1'b1, 8'h41},
        '{1'b1, 8'h80,             1'b1, 8'h80},
        '{1'b1, 8'h7F,             1'b1, 8'h7F},
        '{1'b0, hte_pkg::CHAR_CR,  1'b1, 8'h0D},
        '{1'b0, hte_pkg::CHAR_LF,  1'b1, 8'h0A},
        '{1'b0, hte_pkg::CHAR_SP,  1'b1, 8'h20},
        '{1'b0, hte_pkg::CHAR_TAB, 1'b1, 8'h09},
        '{1'b0, hte_pkg::CHAR_LT,  1'b0, 8'h00},
        '{1'b0, hte_pkg::CHAR_GT,  1'b0, 8'h00},
        '{1'b0, 8'h55,             1'b1, 8'h55},
        '{1'b0, 8'hAA,             1'b1, 8'hAA},
        '{1'b1, hte_pkg::CHAR_TAB, 1'b0, 8'h00},
        '{1'b1, hte_pkg::CHAR_CR,  1'b0, 8'h00},
        '{1'b1, hte_pkg::CHAR_LT,  1'b0, 8'h00}
    };

    html_text_escaper dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .in_byte     (in_byte),
        .empty       (empty),
        .pop         (pop),
        .out_byte    (out_byte),
        .last_of_run (last_of_run),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Appends one expected output beat to the tail of the scoreboard.
    function automatic void add_beat(input logic [7:0] ch, input logic tail);
        out_beat_t beat;
        beat.ch   = ch;
        beat.tail = tail;
        escaped_q.insert(escaped_q.size(), beat);
    endfunction

    // Appends the escaped run of one input byte under the current setting.
    function automatic void escape_char(input logic [7:0] ch);
        string run;
        if (ch == hte_pkg::CHAR_LT)
            run = "&lt;";
        else if (ch == hte_pkg::CHAR_GT)
            run = "&gt;";
        else if (esc_on && ch == hte_pkg::CHAR_CR)
            run = "";
        else if (esc_on && ch == hte_pkg::CHAR_LF)
            run = "<br>";
        else if (esc_on && ch == hte_pkg::CHAR_SP)
            run = "&nbsp;";
        else if (esc_on && ch == hte_pkg::CHAR_TAB)
            run = "&nbsp;&nbsp;&nbsp;";
        else
        begin
            add_beat(ch, 1'b1);
            return;
        end
        for (int i = 0; i < run.len(); i++)
            add_beat(run[i], i == run.len() - 1);
    endfunction

    function automatic logic [7:0] pick_char();
        logic [7:0] ch;
        case ($urandom_range(11))
            0:       ch = hte_pkg::CHAR_LT;
            1:       ch = hte_pkg::CHAR_GT;
            2:       ch = hte_pkg::CHAR_CR;
            3:       ch = hte_pkg::CHAR_LF;
            4:       ch = hte_pkg::CHAR_SP;
            5:       ch = hte_pkg::CHAR_TAB;
            default: ch = 8'($urandom_range(255));
        endcase
        return ch;
    endfunction

    task automatic send_char(input logic [7:0] ch);
        push    <= 1'b1;
        in_byte <= ch;
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    task automatic tx_gap(input int pct);
        int n;
        n = 0;
        while ($urandom_range(99) < pct)
            n++;
        if (n > 0)
        begin
            push <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // The extra idle cycles keep a configuration write well clear of the last transfer.
    task automatic settle();
        push <= 1'b0;
        while (escaped_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_cfg(input logic value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        esc_on = value;
    endtask

    always @(posedge clk)
    begin : out_check
        out_beat_t want;
        if (rst_n && pop && !empty)
        begin
            if (escaped_q.size() == 0)
            begin
                $display("%0t: unexpected transfer, expected none, actual byte %h last %b",
                         $time, out_byte, last_of_run);
                fail_count++;
            end
            else
            begin
                want = escaped_q.pop_front();
                if (out_byte !== want.ch)
                begin
                    $display("%0t: out_byte mismatch, expected %h, actual %h",
                             $time, want.ch, out_byte);
                    fail_count++;
                end
                if (last_of_run !== want.tail)
                begin
                    $display("%0t: last_of_run mismatch, expected %b, actual %b",
                             $time, want.tail, last_of_run);
                    fail_count++;
                end
            end
        end
        pop <= ($urandom_range(99) >= rx_stall_pct);
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    initial
    begin : stimulus
        int tx_pct [4];
        int rx_pct [4];
        logic phase_esc [4];
        tx_pct       = '{0, 82, 0, 37};
        rx_pct       = '{0, 0, 82, 37};
        phase_esc    = '{1'b0, 1'b1, 1'b0, 1'b1};
        rst_n        = 1'b0;
        push         = 1'b0;
        in_byte      = 8'h00;
        pop          = 1'b0;
        cfg_valid    = 1'b0;
        cfg_data     = 1'b0;
        esc_on       = 1'b1;
        rx_stall_pct = 0;
        fail_count   = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < NUM_ROWS; r++)
        begin
            if (stim_table[r].esc != esc_on)
            begin
                settle();
                write_cfg(stim_table[r].esc);
            end
            send_char(stim_table[r].ch);
            if (stim_table[r].typed)
                add_beat(stim_table[r].want, 1'b1);
            else
                escape_char(stim_table[r].ch);
        end

        for (int p = 0; p < 4; p++)
        begin
            settle();
            // The last phase draws its setting at random.
            write_cfg(p == 3 ? 1'($urandom_range(1)) : phase_esc[p]);
            rx_stall_pct = rx_pct[p];
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                logic [7:0] ch;
                ch = pick_char();
                send_char(ch);
                escape_char(ch);
                if (i == PHASE_ITEMS / 2)
                begin
                    // Hold the sender until the output side has fully drained.
                    push <= 1'b0;
                    while (escaped_q.size() != 0)
                        @(posedge clk);
                end
                else if (i != PHASE_ITEMS - 1)
                    tx_gap(tx_pct[p]);
            end
        end

        settle();
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
